/* rtl/core/tcc_pkg.sv */
package tcc_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 2 * CHAR_W;
  localparam int REQ_W  = 3;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);

  // Character and attribute codes
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] SCROLL_COLOR = 8'h8F;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT       = 3'd0,
    REQ_BACKSPACE = 3'd1,
    REQ_SET       = 3'd2,
    REQ_READ      = 3'd3,
    REQ_CLEAR     = 3'd4
  } req_code_t;

  // Linear cell address of a row and column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

endpackage

/* rtl/core/tcc_cmd_if.sv */
interface tcc_cmd_if import tcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_code;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              end_of_string;

  modport source (output valid, req_type, char_code, col, row, end_of_string,
                  input ready);
  modport sink   (input valid, req_type, char_code, col, row, end_of_string,
                  output ready);
endinterface

/* rtl/core/tcc_rsp_if.sv */
interface tcc_rsp_if import tcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [CHAR_W-1:0] cell_char;
  logic [CHAR_W-1:0] cell_color;
  logic              scrolled;
  logic              string_done;

  modport source (output valid, cursor_col, cursor_row, cell_char, cell_color, scrolled,
                  string_done, input ready);
  modport sink   (input valid, cursor_col, cursor_row, cell_char, cell_color, scrolled,
                  string_done, output ready);
endinterface

/* rtl/core/text_console_cursor_scroll.sv */
// A request passes intake, decode and result staging; read cell adds a RAM read state,
// a put that scrolls copies the screen up one row (one cell copied per cycle, then the
// bottom row blanked) and clear screen blanks every cell; the one RAM write port bounds both.
// One request is in work at a time: a new one is taken only once the last result is
// staged, and it is taken while the last result waits.
// Reset (synchronous, active high) homes the cursor and blanks the RAM.
module text_console_cursor_scroll import tcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CHAR_W-1:0] cfg_wdata,
  tcc_cmd_if.sink           cmd,
  tcc_rsp_if.source         rsp
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_SHIFT,
    ST_FILL,
    ST_DONE
  } state_t;

  localparam logic [CNT_W-1:0] SHIFT_LAST = CNT_W'(CELLS - COLUMNS);
  localparam logic [CNT_W-1:0] FILL_LAST  = CNT_W'(CELLS - 1);
  localparam logic [COL_W:0]   COL_LIMIT  = (COL_W + 1)'(COLUMNS);
  localparam logic [ROW_W:0]   ROW_LIMIT  = (ROW_W + 1)'(ROWS);

  state_t            state;
  logic [CNT_W-1:0]  cnt;
  logic              init_pass;
  req_code_t         req_q;
  logic [CHAR_W-1:0] ch_q;
  logic [COL_W-1:0]  x_q;
  logic [ROW_W-1:0]  y_q;
  logic              eos_q;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [CHAR_W-1:0] text_color;
  logic [CHAR_W-1:0] rd_char;
  logic [CHAR_W-1:0] rd_color;
  logic              scrolled_q;

  logic              rsp_valid;
  logic [COL_W-1:0]  rsp_col;
  logic [ROW_W-1:0]  rsp_row;
  logic [CHAR_W-1:0] rsp_char;
  logic [CHAR_W-1:0] rsp_color;
  logic              rsp_scrolled;
  logic              rsp_done;

  // Screen RAM
  logic [CELL_W-1:0] mem [CELLS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  logic              put_nl;
  logic              next_line;
  logic              x_ok;
  logic              y_ok;
  logic              scroll_now;
  logic              read_blank;
  logic [COL_W-1:0]  bs_col;
  logic [ROW_W-1:0]  bs_row;

  // Decode helpers
  assign put_nl     = (ch_q == NEWLINE_CHAR);
  assign next_line  = put_nl || (cur_col == LAST_COL);
  assign x_ok       = ({1'b0, x_q} < COL_LIMIT);
  assign y_ok       = ({1'b0, y_q} < ROW_LIMIT);
  assign scroll_now = (req_q == REQ_PUT) && next_line && (cur_row == LAST_ROW);
  assign read_blank = (req_q == REQ_READ) && !(x_ok && y_ok);

  // Step the cursor back, across a row start if needed, stop at home
  always_comb begin
    bs_col = cur_col;
    bs_row = cur_row;
    if (cur_col != '0) begin
      bs_col = cur_col - 1'b1;
    end else if (cur_row != '0) begin
      bs_col = LAST_COL;
      bs_row = cur_row - 1'b1;
    end
  end

  // Drive the RAM ports from the sequencer
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr(cur_row, cur_col);
    mem_wdata = {text_color, ch_q};
    mem_raddr = cell_addr(y_q, x_q);
    unique case (state)
      ST_DECODE: begin
        if (req_q == REQ_PUT && !put_nl) begin
          mem_we = 1'b1;
        end else if (req_q == REQ_BACKSPACE) begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(bs_row, bs_col);
          mem_wdata = {text_color, BLANK_CHAR};
        end
      end
      ST_SHIFT: begin
        // read one row ahead, write the previous read one cell back
        mem_raddr = ADDR_W'(cnt + CNT_W'(COLUMNS));
        mem_we    = (cnt != '0);
        mem_waddr = ADDR_W'(cnt - 1'b1);
        mem_wdata = mem_rdata;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[ADDR_W-1:0];
        mem_wdata = {SCROLL_COLOR, BLANK_CHAR};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // Sequencer, cursor and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL;
      cnt        <= '0;
      init_pass  <= 1'b1;
      cur_col    <= '0;
      cur_row    <= '0;
      text_color <= SCROLL_COLOR;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        text_color <= cfg_wdata;
      end
      // drop the result once taken, unless a new one is staged now
      if (rsp_valid && rsp.ready && state != ST_DONE) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          // take a request
          if (cmd.valid) begin
            req_q <= req_code_t'(cmd.req_type);
            ch_q  <= cmd.char_code;
            x_q   <= cmd.col;
            y_q   <= cmd.row;
            eos_q <= cmd.end_of_string;
            state <= ST_DECODE;
          end
        end

        ST_DECODE: begin
          rd_char    <= read_blank ? BLANK_CHAR : '0;
          rd_color   <= '0;
          scrolled_q <= scroll_now;
          unique case (req_q)
            REQ_PUT: begin
              if (scroll_now) begin
                cur_col <= '0;
                cnt     <= '0;
                state   <= ST_SHIFT;
              end else if (next_line) begin
                cur_col <= '0;
                cur_row <= cur_row + 1'b1;
                state   <= ST_DONE;
              end else begin
                cur_col <= cur_col + 1'b1;
                state   <= ST_DONE;
              end
            end
            REQ_BACKSPACE: begin
              cur_col <= bs_col;
              cur_row <= bs_row;
              state   <= ST_DONE;
            end
            REQ_SET: begin
              cur_col <= x_ok ? x_q : LAST_COL;
              cur_row <= y_ok ? y_q : LAST_ROW;
              state   <= ST_DONE;
            end
            REQ_READ: begin
              state <= (x_ok && y_ok) ? ST_READ : ST_DONE;
            end
            REQ_CLEAR: begin
              cur_col <= '0;
              cur_row <= '0;
              cnt     <= '0;
              state   <= ST_FILL;
            end
            default: begin
              state <= ST_DONE;
            end
          endcase
        end

        ST_READ: begin
          rd_char  <= mem_rdata[CHAR_W-1:0];
          rd_color <= mem_rdata[CELL_W-1:CHAR_W];
          state    <= ST_DONE;
        end

        ST_SHIFT: begin
          // copy rows up; the bottom row blank follows from the same count
          if (cnt == SHIFT_LAST) begin
            state <= ST_FILL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        ST_FILL: begin
          if (cnt == FILL_LAST) begin
            if (init_pass) begin
              init_pass <= 1'b0;
              state     <= ST_IDLE;
            end else begin
              state <= ST_DONE;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        ST_DONE: begin
          // hold until the result register is free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid    <= 1'b1;
            rsp_col      <= cur_col;
            rsp_row      <= cur_row;
            rsp_char     <= rd_char;
            rsp_color    <= rd_color;
            rsp_scrolled <= scrolled_q;
            rsp_done     <= eos_q;
            state        <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign cmd.ready       = (state == ST_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.cursor_col  = rsp_col;
  assign rsp.cursor_row  = rsp_row;
  assign rsp.cell_char   = rsp_char;
  assign rsp.cell_color  = rsp_color;
  assign rsp.scrolled    = rsp_scrolled;
  assign rsp.string_done = rsp_done;

  // A request closes the intake until its result is staged
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("request taken while another is in work");

  // Cursor never leaves the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cur_col} < COL_LIMIT) && ({1'b0, cur_row} < ROW_LIMIT))
    else $error("cursor out of range");

  // No RAM write while waiting for a request
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !mem_we)
    else $error("screen write while idle");

  // A scroll always leaves the cursor on the last row
  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_scrolled |-> rsp_row == LAST_ROW)
    else $error("scroll reported off the last row");

endmodule

/* sim/text_console_cursor_scroll_test.sv */
import tcc_pkg::*;

typedef struct packed {
  logic [REQ_W-1:0]  kind;
  logic [CHAR_W-1:0] ch;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              eos;
} console_req_t;

typedef struct packed {
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [CHAR_W-1:0] rd_char;
  logic [CHAR_W-1:0] rd_color;
  logic              scrolled;
  logic              done;
} console_rpt_t;

// Screen image, cursor and color as the console should hold them, plus the
// cursor reports still owed by the block in request order.
class console_tracker;
  logic [CELL_W-1:0] cells [CELLS];
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [CHAR_W-1:0] color;
  console_rpt_t      due[$];
  int                errors;

  function new();
    blank_screen();
    cur_col = '0;
    cur_row = '0;
    color   = SCROLL_COLOR;
    errors  = 0;
  endfunction

  function void blank_screen();
    foreach (cells[i]) cells[i] = {SCROLL_COLOR, BLANK_CHAR};
  endfunction

  function int slot(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r);
    return int'(r) * COLUMNS + int'(c);
  endfunction

  // Step down one row; on the last row shift the screen up instead.
  function logic next_line();
    if (cur_row != LAST_ROW) begin
      cur_row++;
      return 1'b0;
    end
    for (int i = 0; i + COLUMNS < CELLS; i++) cells[i] = cells[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = {SCROLL_COLOR, BLANK_CHAR};
    return 1'b1;
  endfunction

  // Apply one accepted request and queue the report it must produce.
  function void take_request(input console_req_t r);
    console_rpt_t want;
    want = '0;
    case (r.kind)
      REQ_PUT: begin
        if (r.ch == NEWLINE_CHAR) begin
          cur_col = '0;
          want.scrolled = next_line();
        end else begin
          cells[slot(cur_col, cur_row)] = {color, r.ch};
          if (cur_col == LAST_COL) begin
            cur_col = '0;
            want.scrolled = next_line();
          end else begin
            cur_col++;
          end
        end
      end
      REQ_BACKSPACE: begin
        if (cur_col != 0) begin
          cur_col--;
        end else if (cur_row != 0) begin
          cur_col = LAST_COL;
          cur_row--;
        end
        cells[slot(cur_col, cur_row)] = {color, BLANK_CHAR};
      end
      REQ_SET: begin
        cur_col = (r.col > LAST_COL) ? LAST_COL : r.col;
        cur_row = (r.row > LAST_ROW) ? LAST_ROW : r.row;
      end
      REQ_READ: begin
        if (r.col <= LAST_COL && r.row <= LAST_ROW) begin
          {want.rd_color, want.rd_char} = cells[slot(r.col, r.row)];
        end else begin
          want.rd_char = BLANK_CHAR;
        end
      end
      REQ_CLEAR: begin
        blank_screen();
        cur_col = '0;
        cur_row = '0;
      end
      default: ;
    endcase
    want.col  = cur_col;
    want.row  = cur_row;
    want.done = r.eos;
    due.push_back(want);
  endfunction

  function void compare(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Match one accepted report against the oldest one owed.
  function void check_report(input console_rpt_t got);
    console_rpt_t want;
    if (due.size() == 0) begin
      errors++;
      $display("%0t: report with none owed, expected nothing, got %0h", $time, got);
      return;
    end
    want = due.pop_front();
    compare("cursor_col", CHAR_W'(want.col), CHAR_W'(got.col));
    compare("cursor_row", CHAR_W'(want.row), CHAR_W'(got.row));
    compare("cell_char", want.rd_char, got.rd_char);
    compare("cell_color", want.rd_color, got.rd_color);
    compare("scrolled", CHAR_W'(want.scrolled), CHAR_W'(got.scrolled));
    compare("string_done", CHAR_W'(want.done), CHAR_W'(got.done));
  endfunction
endclass

module text_console_cursor_scroll_test;

  localparam int LIMIT_CYCLES   = 6_000_000;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT_REPORT = 230;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_FIRST = REQ_W'(REQ_CLEAR + 1);
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_LAST  = '1;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we;
  logic [CHAR_W-1:0] cfg_wdata;
  logic              no_gaps = 1'b0;
  int unsigned       cycle_count = 0;
  console_tracker    tracker;

  tcc_cmd_if cmd ();
  tcc_rsp_if rsp ();

  text_console_cursor_scroll uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (no_gaps || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic console_req_t mk(input logic [REQ_W-1:0] kind, input int ch,
                                      input int c, input int r, input bit eos);
    console_req_t q;
    q.kind = kind;
    q.ch   = CHAR_W'(ch);
    q.col  = COL_W'(c);
    q.row  = ROW_W'(r);
    q.eos  = eos;
    return q;
  endfunction

  // Mostly text and cursor moves, some reads, rare clears and unknown codes.
  function automatic console_req_t random_request();
    console_req_t q;
    int pick;
    q.kind = REQ_PUT;
    q.ch   = CHAR_W'($urandom_range(0, 255));
    q.col  = COL_W'($urandom_range(0, 127));
    q.row  = ROW_W'($urandom_range(0, 31));
    q.eos  = ($urandom_range(0, 7) == 0);
    pick   = $urandom_range(0, 99);
    if (pick < 40) begin
      q.ch = CHAR_W'($urandom_range(8'h20, 8'h7E));
    end else if (pick < 52) begin
      q.kind = REQ_PUT;
    end else if (pick < 58) begin
      q.ch = NEWLINE_CHAR;
    end else if (pick < 68) begin
      q.kind = REQ_BACKSPACE;
    end else if (pick < 78) begin
      q.kind = REQ_SET;
      if ($urandom_range(0, 3) != 0) begin
        q.col = COL_W'($urandom_range(0, COLUMNS - 1));
        q.row = ROW_W'($urandom_range(0, ROWS - 1));
      end
    end else if (pick < 95) begin
      q.kind = REQ_READ;
      if ($urandom_range(0, 5) != 0) begin
        q.col = COL_W'($urandom_range(0, COLUMNS - 1));
        q.row = ($urandom_range(0, 1) == 0) ? tracker.cur_row
                                            : ROW_W'($urandom_range(0, ROWS - 1));
      end
    end else if (pick < 96) begin
      q.kind = REQ_CLEAR;
    end else begin
      q.kind = REQ_W'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
    end
    return q;
  endfunction

  // Offer one request and hold it until taken; valid stays high for the next unless a gap is drawn.
  task automatic send_req(input console_req_t q);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid         <= 1'b1;
    cmd.req_type      <= q.kind;
    cmd.char_code     <= q.ch;
    cmd.col           <= q.col;
    cmd.row           <= q.row;
    cmd.end_of_string <= q.eos;
    do @(posedge clk); while (cmd.ready !== 1'b1);
    tracker.take_request(q);
  endtask

  // Drop valid and wait until every owed report is back.
  task automatic drain_reports();
    cmd.valid <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_color(input logic [CHAR_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.color = v;
  endtask

  task automatic run_random(input int count);
    repeat (count) send_req(random_request());
  endtask

  task automatic run_directed();
    // reset contents, byte extremes, backspace down to and at home
    send_req(mk(REQ_READ, 0, 0, 0, 0));
    send_req(mk(REQ_PUT, 8'h00, 0, 0, 0));
    send_req(mk(REQ_PUT, 8'hFF, 127, 31, 1));
    send_req(mk(REQ_BACKSPACE, 0, 0, 0, 0));
    send_req(mk(REQ_BACKSPACE, 0, 0, 0, 1));
    send_req(mk(REQ_BACKSPACE, 8'hFF, 127, 31, 0));
    // saturated cursor, put at the row end of the last row scrolls
    send_req(mk(REQ_SET, 0, 127, 31, 0));
    send_req(mk(REQ_PUT, 8'h41, 0, 0, 0));
    send_req(mk(REQ_READ, 0, COLUMNS - 1, ROWS - 2, 0));
    send_req(mk(REQ_READ, 0, COLUMNS - 1, ROWS - 1, 1));
    // backspace across a row start, then newlines with and without scroll
    send_req(mk(REQ_BACKSPACE, 0, 0, 0, 0));
    send_req(mk(REQ_PUT, NEWLINE_CHAR, 0, 0, 0));
    send_req(mk(REQ_PUT, NEWLINE_CHAR, 0, 0, 1));
    // reads out of range
    send_req(mk(REQ_READ, 0, 127, 31, 0));
    send_req(mk(REQ_READ, 0, COLUMNS, 0, 0));
    send_req(mk(REQ_READ, 0, 0, ROWS, 0));
    // wrap without scroll
    send_req(mk(REQ_SET, 0, COLUMNS - 1, 0, 0));
    send_req(mk(REQ_PUT, 8'h7F, 0, 0, 0));
    send_req(mk(REQ_READ, 0, COLUMNS - 1, 0, 0));
    // unknown codes change nothing
    send_req(mk(REQ_UNKNOWN_FIRST, 8'hFF, 127, 31, 1));
    send_req(mk(REQ_W'(REQ_UNKNOWN_FIRST + 1), 0, 0, 0, 0));
    send_req(mk(REQ_UNKNOWN_LAST, 8'h55, 42, 21, 1));
    // clear, then look at the home cell
    send_req(mk(REQ_CLEAR, 0, 0, 0, 0));
    send_req(mk(REQ_READ, 0, 0, 0, 1));
  endtask

  // Main sequence: reset, directed part, then random phases per color
  initial begin
    tracker = new();
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    cmd.valid         <= 1'b0;
    cmd.req_type      <= '0;
    cmd.char_code     <= '0;
    cmd.col           <= '0;
    cmd.row           <= '0;
    cmd.end_of_string <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    drain_reports();
    write_color(8'h00);
    run_random(160);
    drain_reports();
    write_color(8'hFF);
    no_gaps = 1'b1;
    run_random(160);
    drain_reports();
    no_gaps = 1'b0;
    write_color(CHAR_W'($urandom_range(1, 254)));
    run_random(160);
    drain_reports();
    write_color(CHAR_W'($urandom_range(1, 254)));
    run_random(170);
    drain_reports();

    if (tracker.errors == 0 && tracker.due.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Take reports with random stalls; hold off once long enough to back up requests
  initial begin
    int gap;
    int taken;
    console_rpt_t got;
    taken = 0;
    rsp.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = (taken == HOLD_AT_REPORT) ? HOLD_CYCLES : draw_gap();
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (rsp.valid !== 1'b1);
      got.col      = rsp.cursor_col;
      got.row      = rsp.cursor_row;
      got.rd_char  = rsp.cell_char;
      got.rd_color = rsp.cell_color;
      got.scrolled = rsp.scrolled;
      got.done     = rsp.string_done;
      tracker.check_report(got);
      taken++;
    end
  end

endmodule
